// ----- design/jbdo_pkg.sv -----
// ============================================================================
// jbdo_pkg
// Shared constants, codes, types and helpers for the jitter buffer.
// ============================================================================
package jbdo_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int DATA_W     = 32;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int MINF_W     = 5;
    localparam int INTV_W     = 10;
    localparam int LAT_W      = 14;
    localparam int PCT_W      = 7;
    localparam int FILL_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUFFERING = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERRUN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

    localparam logic [MINF_W-1:0] MIN_FILL_RST = 5'd3;
    localparam logic [INTV_W-1:0] INTERVAL_RST = 10'd50;
    localparam logic [LAT_W-1:0]  LAT_MAX      = 14'd16383;
    localparam int                PCT_SCALE    = 100;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] pos_x;
        logic [DATA_W-1:0] pos_y;
        logic [DATA_W-1:0] stamp;
    } t_req;

    typedef struct packed {
        logic              out_valid;
        logic [DATA_W-1:0] out_x;
        logic [DATA_W-1:0] out_y;
        logic [DATA_W-1:0] out_stamp;
        logic [STAT_W-1:0] status;
        logic              ready_res;
        logic [LAT_W-1:0]  latency_ms;
        logic [PCT_W-1:0]  health_pct;
        logic [FILL_W-1:0] fill;
        logic              playing;
        logic [DATA_W-1:0] start_stamp;
    } t_res;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

// ----- design/jbdo_in_stage.sv -----
// ============================================================================
// jbdo_in_stage
// Input register that holds one request until the core takes it.
// ============================================================================
module jbdo_in_stage
    import jbdo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    input  logic i_take,
    output logic o_vld,
    output t_req o_req
);

    logic r_vld;
    t_req r_req;

    assign o_ready = !r_vld || i_take;
    assign o_vld   = r_vld;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

// ----- design/jbdo_core.sv -----
// ============================================================================
// jbdo_core
// Queue state, entry store and the single-pass request logic.
// ============================================================================
module jbdo_core
    import jbdo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_req              i_req,
    input  logic [MINF_W-1:0] i_min_fill,
    input  logic [INTV_W-1:0] i_interval,
    output t_res              o_res
);

    logic [3*DATA_W-1:0] r_mem [DEPTH];

    logic [IDX_W-1:0]  r_head,  n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_play,  n_play;
    logic [DATA_W-1:0] r_start, n_start;

    logic                    full;
    logic [CNT_W-1:0]        base_cnt;
    logic [IDX_W:0]          tail_sum;
    logic [IDX_W-1:0]        tail;
    logic                    wr_en;
    logic [3*DATA_W-1:0]     rd_data;
    logic [CNT_W+INTV_W-1:0] lat_prod;
    logic [CNT_W+7:0]        pct_prod;
    logic                    reach_min;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign base_cnt = full ? CNT_W'(DEPTH - 1) : r_count;
    assign tail_sum = {1'b0, r_head} + (IDX_W + 1)'(r_count);
    assign rd_data  = r_mem[r_head];

    always_comb begin
        if (full) begin
            tail = r_head;
        end else if (tail_sum >= (IDX_W + 1)'(DEPTH)) begin
            tail = IDX_W'(tail_sum - (IDX_W + 1)'(DEPTH));
        end else begin
            tail = IDX_W'(tail_sum);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_play  = r_play;
        n_start = r_start;
        wr_en   = 1'b0;
        o_res   = '0;

        unique case (i_req.req_type)
            REQ_INSERT: begin
                wr_en   = 1'b1;
                n_head  = full ? next_idx(r_head) : r_head;
                n_count = base_cnt + 1'b1;
                if (!r_play && (16'(n_count) >= 16'(i_min_fill))) begin
                    n_play  = 1'b1;
                    n_start = i_req.stamp;
                end
            end
            REQ_POP: begin
                if (!r_play) begin
                    o_res.status = ST_BUFFERING;
                end else if (r_count == '0) begin
                    o_res.status = ST_UNDERRUN;
                end else begin
                    o_res.out_valid = 1'b1;
                    o_res.out_x     = rd_data[3*DATA_W-1:2*DATA_W];
                    o_res.out_y     = rd_data[2*DATA_W-1:DATA_W];
                    o_res.out_stamp = rd_data[DATA_W-1:0];
                    n_head          = next_idx(r_head);
                    n_count         = r_count - 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_head  = '0;
                n_count = '0;
                n_play  = 1'b0;
                n_start = '0;
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase

        lat_prod  = (CNT_W + INTV_W)'(n_count) * (CNT_W + INTV_W)'(i_interval);
        pct_prod  = (CNT_W + 8)'(n_count) * (CNT_W + 8)'(PCT_SCALE);
        reach_min = (16'(n_count) >= 16'(i_min_fill));

        if (!n_play) begin
            o_res.latency_ms = '0;
        end else if (lat_prod > (CNT_W + INTV_W)'(LAT_MAX)) begin
            o_res.latency_ms = LAT_MAX;
        end else begin
            o_res.latency_ms = LAT_W'(lat_prod);
        end

        o_res.ready_res   = n_play || reach_min;
        o_res.health_pct  = PCT_W'(pct_prod / DEPTH);
        o_res.fill        = FILL_W'(n_count);
        o_res.playing     = n_play;
        o_res.start_stamp = n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_play  <= 1'b0;
            r_start <= '0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_play  <= n_play;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_mem[tail] <= {i_req.pos_x, i_req.pos_y, i_req.stamp};
        end
    end

endmodule

// ----- design/jbdo_out_stage.sv -----
// ============================================================================
// jbdo_out_stage
// Result register that holds one result item until it is taken.
// ============================================================================
module jbdo_out_stage
    import jbdo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_res i_res,
    output logic o_space,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic r_vld;
    t_res r_res;

    assign o_space = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_space) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- design/jitter_buffer_drop_oldest.sv -----
// ============================================================================
// jitter_buffer_drop_oldest
// Sixteen-entry position jitter buffer that drops its oldest entry when full.
// ============================================================================
// Each request (insert, pop or clear) gives exactly one result item. A request
// is registered at the input, processed in one pass against the queue state and
// the entry store, and registered at the output; a new request is taken every
// cycle while the output side keeps up. The configuration registers are written
// through a plain write port; the user must write them only while the block is
// idle, and the block itself does not enforce this. There is no clearing pass.
module jitter_buffer_drop_oldest
    import jbdo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_W-1:0]     i_pos_x,
    input  logic [DATA_W-1:0]     i_pos_y,
    input  logic [DATA_W-1:0]     i_stamp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_out_valid,
    output logic [DATA_W-1:0]     o_out_x,
    output logic [DATA_W-1:0]     o_out_y,
    output logic [DATA_W-1:0]     o_out_stamp,
    output logic [STAT_W-1:0]     o_status,
    output logic                  o_ready_res,
    output logic [LAT_W-1:0]      o_latency_ms,
    output logic [PCT_W-1:0]      o_health_pct,
    output logic [FILL_W-1:0]     o_fill,
    output logic                  o_playing,
    output logic [DATA_W-1:0]     o_start_stamp
);

    logic [MINF_W-1:0] r_min_fill;
    logic [INTV_W-1:0] r_interval;

    t_req in_req;
    t_req stg_req;
    logic stg_vld;
    logic out_space;
    logic fire;
    t_res core_res;
    t_res out_res;

    assign in_req.req_type = i_req_type;
    assign in_req.pos_x    = i_pos_x;
    assign in_req.pos_y    = i_pos_y;
    assign in_req.stamp    = i_stamp;

    assign fire = stg_vld && out_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fill <= MIN_FILL_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_FILL: r_min_fill <= i_cfg_data[MINF_W-1:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[INTV_W-1:0];
                default:      r_interval <= r_interval;
            endcase
        end
    end

    jbdo_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (in_req),
        .i_take  (fire),
        .o_vld   (stg_vld),
        .o_req   (stg_req)
    );

    jbdo_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req      (stg_req),
        .i_min_fill (r_min_fill),
        .i_interval (r_interval),
        .o_res      (core_res)
    );

    jbdo_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (core_res),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_out_valid   = out_res.out_valid;
    assign o_out_x       = out_res.out_x;
    assign o_out_y       = out_res.out_y;
    assign o_out_stamp   = out_res.out_stamp;
    assign o_status      = out_res.status;
    assign o_ready_res   = out_res.ready_res;
    assign o_latency_ms  = out_res.latency_ms;
    assign o_health_pct  = out_res.health_pct;
    assign o_fill        = out_res.fill;
    assign o_playing     = out_res.playing;
    assign o_start_stamp = out_res.start_stamp;

endmodule
